@@ sv/pbcm_pkg.sv @@
// shared constants, types and register codes for the perspective banner coordinate map
`timescale 1ns / 1ps
`default_nettype none

package pbcm_pkg;

   localparam int BANNER_WIDTH  = 1024;
   localparam int BANNER_HEIGHT = 1024;

   localparam int NUM_COEFS  = 8;
   localparam int COEF_IDX_W = $clog2(NUM_COEFS);
   localparam int CSR_IDX_W  = COEF_IDX_W + 1;
   localparam int COEF_W     = 48;
   localparam int IN_W       = 13;
   localparam int OUT_W      = 10;

   localparam int MAX_SIZE = (BANNER_WIDTH > BANNER_HEIGHT) ? BANNER_WIDTH : BANNER_HEIGHT;
   localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
   localparam int QUO_W    = $clog2(MAX_SIZE);
   localparam int PROD_W   = COEF_W + IN_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int NUM_W    = SUM_W + SIZE_W + 1;

   localparam logic [COEF_IDX_W-1:0] COEF_XX = COEF_IDX_W'(0);
   localparam logic [COEF_IDX_W-1:0] COEF_XY = COEF_IDX_W'(1);
   localparam logic [COEF_IDX_W-1:0] COEF_XT = COEF_IDX_W'(2);
   localparam logic [COEF_IDX_W-1:0] COEF_YX = COEF_IDX_W'(3);
   localparam logic [COEF_IDX_W-1:0] COEF_YY = COEF_IDX_W'(4);
   localparam logic [COEF_IDX_W-1:0] COEF_YT = COEF_IDX_W'(5);
   localparam logic [COEF_IDX_W-1:0] COEF_WX = COEF_IDX_W'(6);
   localparam logic [COEF_IDX_W-1:0] COEF_WY = COEF_IDX_W'(7);

   // 1.0 in q16.32, and the denominator constant 1.0 scaled by two
   localparam logic [COEF_W-1:0]        COEF_ONE = COEF_W'(64'h1_0000_0000);
   localparam logic signed [SUM_W-1:0]  DEN_ONE  = SUM_W'(64'h2_0000_0000);

   localparam logic [NUM_W-1:0] WIDTH_NUM  = NUM_W'(BANNER_WIDTH);
   localparam logic [NUM_W-1:0] HEIGHT_NUM = NUM_W'(BANNER_HEIGHT);

   typedef logic [COEF_W-1:0] coef_type;
   typedef coef_type [NUM_COEFS-1:0] coef_bank_type;

   // identity mapping, highest index first
   localparam coef_bank_type COEF_RESET = {{3{COEF_W'(0)}}, COEF_ONE,
                                           {3{COEF_W'(0)}}, COEF_ONE};

   typedef struct packed {
      logic [NUM_W-1:0] rem_x;
      logic [NUM_W-1:0] rem_y;
      logic [NUM_W-1:0] dsh;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      logic             in_banner;
   } div_type;

endpackage

`default_nettype wire

@@ sv/pbcm_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface pbcm_req_if import pbcm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IN_W-1:0]   offset_x_half;
   logic [IN_W-1:0]   offset_y_half;

   modport source (output valid, output offset_x_half, output offset_y_half, input ready);
   modport sink (input valid, input offset_x_half, input offset_y_half, output ready);
endinterface

interface pbcm_rsp_if import pbcm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OUT_W-1:0]  banner_col;
   logic [OUT_W-1:0]  banner_row;
   logic              inside_res;

   modport source (output valid, output banner_col, output banner_row, output inside_res,
                   input ready);
   modport sink (input valid, input banner_col, input banner_row, input inside_res,
                 output ready);
endinterface

`default_nettype wire

@@ sv/perspective_banner_coordinate_map.sv @@
// pipeline: 5 front stages, 10 division cells and one output register from request transfer
//   to response; one division cell per quotient bit of the banner size
// throughput: one item per clock while the response side accepts; any stage can stall the chain
// reset: coefficients return to the identity mapping and every pipeline stage empties;
//   there is no memory and no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module perspective_banner_coordinate_map import pbcm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   pbcm_req_if.sink                  req,
   pbcm_rsp_if.source                rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_wdata
);

   coef_bank_type    coef_ff, coef_in;

   logic [QUO_W:0]   chain_valid;
   logic [QUO_W:0]   chain_ready;
   div_type          chain_data [QUO_W+1];

   logic             out_valid_ff, out_valid_in;
   logic [OUT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic             hit_ff, hit_in;
   logic             out_load;

   // coefficient registers
   always_comb begin
      coef_in = coef_ff;
      if (csr_we && (csr_index < CSR_IDX_W'(NUM_COEFS))) begin
         coef_in[csr_index[COEF_IDX_W-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   pbcm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .coef_bank (coef_ff),
      .dn_ready  (chain_ready[0]),
      .dn_valid  (chain_valid[0]),
      .dn_data   (chain_data[0])
   );

   for (genvar i = 0; i < QUO_W; i++) begin : g_cell
      pbcm_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_data  (chain_data[i]),
         .up_ready (chain_ready[i]),
         .dn_ready (chain_ready[i+1]),
         .dn_valid (chain_valid[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   // output register
   assign out_load           = !out_valid_ff || rsp.ready;
   assign chain_ready[QUO_W] = out_load;

   always_comb begin
      out_valid_in = out_load ? chain_valid[QUO_W] : out_valid_ff;
      hit_in       = chain_data[QUO_W].in_banner;
      col_in       = hit_in ? OUT_W'(chain_data[QUO_W].quo_x) : '0;
      row_in       = hit_in ? OUT_W'(chain_data[QUO_W].quo_y) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         col_ff <= col_in;
         row_ff <= row_in;
         hit_ff <= hit_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.banner_col = col_ff;
   assign rsp.banner_row = row_ff;
   assign rsp.inside_res = hit_ff;

`ifndef SYNTH
   a_input_stall_needs_full_chain : assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp.valid && !rsp.ready))
      else $error("request stalled while the response side is free");

   a_outside_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.inside_res) |-> (rsp.banner_col == '0 && rsp.banner_row == '0))
      else $error("outside response carries a nonzero coordinate");

   a_reset_identity : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (coef_ff[COEF_XX] == COEF_ONE && coef_ff[COEF_YY] == COEF_ONE &&
                        coef_ff[COEF_WX] == '0 && coef_ff[COEF_WY] == '0))
      else $error("coefficients not at identity after reset");
`endif

endmodule

`default_nettype wire

@@ sv/pbcm_front.sv @@
// front pipeline: products, sums, size offset, sign fix and range check
`timescale 1ns / 1ps
`default_nettype none

module pbcm_front import pbcm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   pbcm_req_if.sink           req,
   input  wire coef_bank_type coef_bank,
   input  wire logic          dn_ready,
   output logic               dn_valid,
   output div_type            dn_data
);

   localparam int STAGES = 5;

   function automatic logic signed [PROD_W-1:0] mul_coef(input logic [COEF_W-1:0] c,
                                                         input logic [IN_W-1:0] v);
      logic signed [PROD_W-1:0] ce;
      logic signed [PROD_W-1:0] ve;
      ce = PROD_W'($signed(c));
      ve = PROD_W'($signed(v));
      return ce * ve;
   endfunction

   logic [STAGES-1:0] load;
   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] v_in;

   logic signed [PROD_W-1:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff, pwx_ff, pwy_ff;
   logic signed [PROD_W-1:0] pxx_in, pxy_in, pyx_in, pyy_in, pwx_in, pwy_in;
   logic signed [SUM_W-1:0]  nx_ff, ny_ff, d_ff;
   logic signed [SUM_W-1:0]  nx_in, ny_in, d_in;
   logic signed [NUM_W-1:0]  px_ff, py_ff;
   logic signed [NUM_W-1:0]  px_in, py_in;
   logic signed [SUM_W-1:0]  d2_ff, d2_in;
   logic [NUM_W-1:0]         n3x_ff, n3y_ff, n3x_in, n3y_in;
   logic [SUM_W-1:0]         den_ff, den_in;
   logic signed [SUM_W-1:0]  dmag;
   logic                     zero_ff, zero_in;
   logic [NUM_W-1:0]         wd, hd;
   logic                     in_x, in_y;
   div_type                  div_ff, div_in;

   always_comb begin
      load[4] = !v_ff[4] || dn_ready;
      load[3] = !v_ff[3] || load[4];
      load[2] = !v_ff[2] || load[3];
      load[1] = !v_ff[1] || load[2];
      load[0] = !v_ff[0] || load[1];
   end

   assign req.ready = load[0];
   assign dn_valid  = v_ff[4];
   assign dn_data   = div_ff;

   always_comb begin
      v_in[0] = load[0] ? req.valid : v_ff[0];
      v_in[1] = load[1] ? v_ff[0] : v_ff[1];
      v_in[2] = load[2] ? v_ff[1] : v_ff[2];
      v_in[3] = load[3] ? v_ff[2] : v_ff[3];
      v_in[4] = load[4] ? v_ff[3] : v_ff[4];
   end

   // stage 0: six products
   always_comb begin
      pxx_in = mul_coef(coef_bank[COEF_XX], req.offset_x_half);
      pxy_in = mul_coef(coef_bank[COEF_XY], req.offset_y_half);
      pyx_in = mul_coef(coef_bank[COEF_YX], req.offset_x_half);
      pyy_in = mul_coef(coef_bank[COEF_YY], req.offset_y_half);
      pwx_in = mul_coef(coef_bank[COEF_WX], req.offset_x_half);
      pwy_in = mul_coef(coef_bank[COEF_WY], req.offset_y_half);
   end

   // stage 1: numerators and denominator, all scaled by two
   always_comb begin
      nx_in = SUM_W'(pxx_ff) + SUM_W'(pxy_ff) + (SUM_W'($signed(coef_bank[COEF_XT])) <<< 1);
      ny_in = SUM_W'(pyx_ff) + SUM_W'(pyy_ff) + (SUM_W'($signed(coef_bank[COEF_YT])) <<< 1);
      d_in  = SUM_W'(pwx_ff) + SUM_W'(pwy_ff) + DEN_ONE;
   end

   // stage 2: 2*num + size*den
   always_comb begin
      px_in = (NUM_W'(nx_ff) <<< 1) + NUM_W'(d_ff) * WIDTH_NUM;
      py_in = (NUM_W'(ny_ff) <<< 1) + NUM_W'(d_ff) * HEIGHT_NUM;
      d2_in = d_ff;
   end

   // stage 3: make the denominator positive
   always_comb begin
      dmag    = d2_ff[SUM_W-1] ? -d2_ff : d2_ff;
      n3x_in  = d2_ff[SUM_W-1] ? -px_ff : px_ff;
      n3y_in  = d2_ff[SUM_W-1] ? -py_ff : py_ff;
      den_in  = dmag << 1;
      zero_in = (d2_ff == '0);
   end

   // stage 4: strictly inside when 0 < n < size*den
   always_comb begin
      wd   = NUM_W'(den_ff) * WIDTH_NUM;
      hd   = NUM_W'(den_ff) * HEIGHT_NUM;
      in_x = !n3x_ff[NUM_W-1] && (n3x_ff != '0) && (n3x_ff < wd);
      in_y = !n3y_ff[NUM_W-1] && (n3y_ff != '0) && (n3y_ff < hd);
      div_in.rem_x     = n3x_ff;
      div_in.rem_y     = n3y_ff;
      div_in.dsh       = NUM_W'(den_ff) << (QUO_W - 1);
      div_in.quo_x     = '0;
      div_in.quo_y     = '0;
      div_in.in_banner = !zero_ff && in_x && in_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         pxx_ff <= pxx_in;
         pxy_ff <= pxy_in;
         pyx_ff <= pyx_in;
         pyy_ff <= pyy_in;
         pwx_ff <= pwx_in;
         pwy_ff <= pwy_in;
      end
      if (load[1]) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         d_ff  <= d_in;
      end
      if (load[2]) begin
         px_ff <= px_in;
         py_ff <= py_in;
         d2_ff <= d2_in;
      end
      if (load[3]) begin
         n3x_ff  <= n3x_in;
         n3y_ff  <= n3y_in;
         den_ff  <= den_in;
         zero_ff <= zero_in;
      end
      if (load[4]) begin
         div_ff <= div_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/pbcm_div_cell.sv @@
// one restoring division cell: one quotient bit per axis
`timescale 1ns / 1ps
`default_nettype none

module pbcm_div_cell import pbcm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    up_valid,
   input  wire div_type up_data,
   output logic         up_ready,
   input  wire logic    dn_ready,
   output logic         dn_valid,
   output div_type      dn_data
);

   logic    valid_ff, valid_in;
   div_type data_ff, data_in;
   logic    bit_x, bit_y;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      bit_x = (up_data.rem_x >= up_data.dsh);
      bit_y = (up_data.rem_y >= up_data.dsh);
      data_in.rem_x     = bit_x ? up_data.rem_x - up_data.dsh : up_data.rem_x;
      data_in.rem_y     = bit_y ? up_data.rem_y - up_data.dsh : up_data.rem_y;
      data_in.dsh       = up_data.dsh >> 1;
      data_in.quo_x     = QUO_W'({up_data.quo_x, bit_x});
      data_in.quo_y     = QUO_W'({up_data.quo_y, bit_y});
      data_in.in_banner = up_data.in_banner;
      valid_in          = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire
